// ===== hdl/rcfd_pkg.sv =====
// Shared types and constants for the RC channel frame decoder.
// No dependencies; compile first.
package rcfd_pkg;

	localparam int BYTE_W  = 8;
	localparam int CHAN_W  = 16;
	localparam int COUNT_W = 4;
	localparam int POS_W   = 5;

	localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h20;
	localparam logic [CHAN_W-1:0] CHECK_INIT = 16'hFFFF;

	// Parser phases
	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_CMD  = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;
	localparam logic [1:0] PH_CKHI = 2'd3;

	// Action codes of a request
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// Configuration register indexes
	localparam logic REG_CHANNEL_COUNT = 1'b0;

	typedef logic [CHAN_W-1:0] chan_word_t;

endpackage

// ===== hdl/rcfd_if.sv =====
// Request and response channel interfaces of the RC channel frame decoder.
// Depends on rcfd_pkg for field widths.
interface rcfd_req_if;
	logic                           valid;
	logic                           ready;
	logic                           action;
	logic [rcfd_pkg::BYTE_W-1:0]    rx_byte;
	logic [rcfd_pkg::COUNT_W-1:0]   channel_number;

	modport source(output valid, action, rx_byte, channel_number, input ready);
	modport sink(input valid, action, rx_byte, channel_number, output ready);
endinterface

interface rcfd_rsp_if;
	logic                 valid;
	logic                 ready;
	rcfd_pkg::chan_word_t read_value;
	logic                 frame_accepted;
	logic                 checksum_error;

	modport source(output valid, read_value, frame_accepted, checksum_error, input ready);
	modport sink(input valid, read_value, frame_accepted, checksum_error, output ready);
endinterface

// ===== hdl/rcfd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rcfd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/rc_channel_frame_decoder.sv =====
// RC channel frame decoder: byte-wise frame parser with a two-copy channel RAM.
// Each request passes the stage 1 register (parse + RAM read) and then the output register.
// Throughput: one request per cycle while the output register can drain; set by the
// single RAM read port and the parse update. Commit flips per-channel copy pointers at once.
// Reset (arst_n low): parser hunts for sync, committed channels read as zero,
// channel_count returns to 14. Depends on rcfd_pkg, rcfd_if and rcfd_ram.
module rc_channel_frame_decoder #(
	parameter int MAX_CHANNELS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	rcfd_req_if.sink    req,
	rcfd_rsp_if.source  rsp
);

	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int AW    = IDX_W + 1;
	localparam int DEPTH = 2 ** AW;
	localparam logic [rcfd_pkg::COUNT_W-1:0] MAX_CNT = rcfd_pkg::COUNT_W'(MAX_CHANNELS);
	localparam logic [rcfd_pkg::POS_W-1:0]   MAX_POS = rcfd_pkg::POS_W'(2 * MAX_CHANNELS);

	// Configuration
	logic [rcfd_pkg::COUNT_W-1:0] count_q;
	logic [rcfd_pkg::COUNT_W-1:0] cnt;
	logic [rcfd_pkg::POS_W-1:0]   two_cnt;
	logic                         cfg_wr;

	// Parser state
	logic [1:0]                        phase_q;
	logic [rcfd_pkg::POS_W-1:0]        pos_q;
	rcfd_pkg::chan_word_t              chk_q;
	logic [rcfd_pkg::BYTE_W-1:0]       low_q;

	// Per-channel copy pointers: committed copy, staging copy, staging written, committed valid
	logic [MAX_CHANNELS-1:0] cur_q;
	logic [MAX_CHANNELS-1:0] sv_q;
	logic [MAX_CHANNELS-1:0] stw_q;
	logic [MAX_CHANNELS-1:0] cvalid_q;

	// Pipeline
	logic                 v_s1, hit_s1, ok_s1, bad_s1;
	logic                 rsp_valid_q, ok_q, bad_q;
	rcfd_pkg::chan_word_t value_q;
	rcfd_pkg::chan_word_t rdata;
	logic                 adv;

	// Request decode
	logic                         accept, byte_acc, read_acc;
	logic [rcfd_pkg::COUNT_W-1:0] num_m1;
	logic [IDX_W-1:0]             rd_idx, wr_idx;
	logic                         in_range, rd_hit;
	logic                         data_byte, ck_byte, sum_good;
	logic                         ram_we, ram_re;
	logic [AW-1:0]                ram_waddr, ram_raddr;
	rcfd_pkg::chan_word_t         ram_wdata, got;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[2] == rcfd_pkg::REG_CHANNEL_COUNT);
	assign prdata = (paddr[2] == rcfd_pkg::REG_CHANNEL_COUNT)
		? {{(32 - rcfd_pkg::COUNT_W){1'b0}}, count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 4'd14;
		end else if (cfg_wr) begin
			count_q <= pwdata[rcfd_pkg::COUNT_W-1:0];
		end
	end

	assign cnt     = (count_q > MAX_CNT) ? MAX_CNT : count_q;
	assign two_cnt = {cnt, 1'b0};

	assign adv       = v_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !v_s1 || adv;
	assign accept    = req.valid && req.ready;
	assign byte_acc  = accept && (req.action == rcfd_pkg::ACT_BYTE);
	assign read_acc  = accept && (req.action == rcfd_pkg::ACT_READ);

	assign num_m1   = req.channel_number - 4'd1;
	assign rd_idx   = num_m1[IDX_W-1:0];
	assign in_range = (req.channel_number != '0) && (req.channel_number <= cnt);
	assign rd_hit   = in_range && cvalid_q[rd_idx];

	assign wr_idx    = pos_q[IDX_W:1];
	assign data_byte = byte_acc && (phase_q == rcfd_pkg::PH_DATA) && (pos_q < two_cnt);
	assign ck_byte   = byte_acc && (phase_q == rcfd_pkg::PH_CKHI);
	assign got       = {req.rx_byte, low_q};
	assign sum_good  = (got == chk_q);

	// Staging writes go to the copy not holding the committed value, so a read
	// never meets a write to the same entry and no forwarding is required.
	assign ram_we    = data_byte && pos_q[0];
	assign ram_waddr = {~cur_q[wr_idx], wr_idx};
	assign ram_wdata = {req.rx_byte, low_q};
	assign ram_re    = read_acc && rd_hit;
	assign ram_raddr = {cur_q[rd_idx], rd_idx};

	rcfd_ram #(
		.WIDTH(rcfd_pkg::CHAN_W),
		.DEPTH(DEPTH)
	) u_chan_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= rcfd_pkg::PH_HUNT;
			pos_q    <= '0;
			chk_q    <= rcfd_pkg::CHECK_INIT;
			low_q    <= '0;
			cur_q    <= '0;
			sv_q     <= '0;
			stw_q    <= '0;
			cvalid_q <= '0;
		end else if (byte_acc) begin
			unique case (phase_q)
				rcfd_pkg::PH_HUNT: begin
					if (req.rx_byte == rcfd_pkg::SYNC_BYTE) begin
						chk_q   <= rcfd_pkg::CHECK_INIT - {8'd0, rcfd_pkg::SYNC_BYTE};
						phase_q <= rcfd_pkg::PH_CMD;
					end
				end
				rcfd_pkg::PH_CMD: begin
					chk_q   <= chk_q - {8'd0, req.rx_byte};
					pos_q   <= '0;
					phase_q <= rcfd_pkg::PH_DATA;
				end
				rcfd_pkg::PH_DATA: begin
					if (pos_q < two_cnt) begin
						chk_q <= chk_q - {8'd0, req.rx_byte};
						if (!pos_q[0]) begin
							low_q <= req.rx_byte;
						end else begin
							sv_q[wr_idx]  <= ~cur_q[wr_idx];
							stw_q[wr_idx] <= 1'b1;
						end
						pos_q <= pos_q + 5'd1;
					end else begin
						low_q   <= req.rx_byte;
						phase_q <= rcfd_pkg::PH_CKHI;
					end
				end
				rcfd_pkg::PH_CKHI: begin
					if (sum_good) begin
						// commit: point each counted channel at its staging copy
						for (int i = 0; i < MAX_CHANNELS; i++) begin
							if (rcfd_pkg::COUNT_W'(i) < cnt) begin
								cur_q[i]    <= sv_q[i];
								cvalid_q[i] <= stw_q[i];
							end
						end
					end
					phase_q <= rcfd_pkg::PH_HUNT;
					pos_q   <= '0;
					chk_q   <= rcfd_pkg::CHECK_INIT;
				end
				default: begin
					phase_q <= rcfd_pkg::PH_HUNT;
				end
			endcase
		end
	end

	// Stage 1: RAM read in flight; hold while the output register is full and not being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1 <= read_acc && rd_hit;
			ok_s1  <= ck_byte && sum_good;
			bad_s1 <= ck_byte && !sum_good;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_q <= hit_s1 ? rdata : '0;
			ok_q    <= ok_s1;
			bad_q   <= bad_s1;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.read_value     = value_q;
	assign rsp.frame_accepted = ok_q;
	assign rsp.checksum_error = bad_q;

	// Checks
	assert property (@(posedge clk) disable iff (!arst_n)
		ck_byte |=> (phase_q == rcfd_pkg::PH_HUNT) && (chk_q == rcfd_pkg::CHECK_INIT))
		else $error("parser did not return to hunting after a checksum byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> v_s1 && $stable(hit_s1) && (!hit_s1 || $stable(rdata)))
		else $error("stalled stage 1 request lost its read data");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(ok_q && bad_q))
		else $error("frame reported both accepted and in error");

	assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= MAX_POS)
		else $error("byte position ran past the channel area");

	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("channel RAM read and write collided");

endmodule

// ===== dv/rcfd_checker.sv =====
`timescale 1ns / 1ps
// Response checker for rc_channel_frame_decoder: snoops the register port and both
// channels, predicts each response and compares it field by field.
// Depends on rcfd_pkg and the rcfd_req_if / rcfd_rsp_if interfaces.
module rcfd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	rcfd_req_if         req,
	rcfd_rsp_if         rsp,
	output int unsigned fail_count,
	output int unsigned owed
);

	localparam int NUM_CH = 14;
	localparam logic [2:0] COUNT_ADDR = 3'(4 * rcfd_pkg::REG_CHANNEL_COUNT);

	typedef struct packed {
		rcfd_pkg::chan_word_t read_value;
		logic                 frame_accepted;
		logic                 checksum_error;
	} reply_t;

	reply_t                                owed_replies[$];
	logic [1:0]                            phase;
	logic [rcfd_pkg::POS_W-1:0]            pos;
	rcfd_pkg::chan_word_t                  csum;
	logic [rcfd_pkg::BYTE_W-1:0]           low_hold;
	rcfd_pkg::chan_word_t                  staged[NUM_CH];
	rcfd_pkg::chan_word_t                  shown[NUM_CH];
	logic [rcfd_pkg::COUNT_W-1:0]          chan_count;

	initial begin
		fail_count = 0;
		owed = 0;
	end

	// Predict the response to one request; a byte request also advances the parser.
	function automatic reply_t decode_request(logic act, logic [rcfd_pkg::BYTE_W-1:0] b,
			logic [rcfd_pkg::COUNT_W-1:0] num);
		reply_t r;
		int unsigned words;
		r = '0;
		words = (chan_count > NUM_CH) ? NUM_CH : chan_count;
		if (act == rcfd_pkg::ACT_READ) begin
			if (num != 0 && num <= words)
				r.read_value = shown[num - 1];
			return r;
		end
		case (phase)
		rcfd_pkg::PH_HUNT: begin
			if (b == rcfd_pkg::SYNC_BYTE) begin
				csum = rcfd_pkg::CHECK_INIT - rcfd_pkg::SYNC_BYTE;
				phase = rcfd_pkg::PH_CMD;
			end
		end
		rcfd_pkg::PH_CMD: begin
			csum = csum - b;
			pos = '0;
			phase = rcfd_pkg::PH_DATA;
		end
		rcfd_pkg::PH_DATA: begin
			// the count in force now decides whether this is still channel data
			if (pos < 2 * words) begin
				csum = csum - b;
				if (!pos[0])
					low_hold = b;
				else
					staged[pos >> 1] = {b, low_hold};
				pos = pos + 1'b1;
			end else begin
				low_hold = b;
				phase = rcfd_pkg::PH_CKHI;
			end
		end
		default: begin
			if ({b, low_hold} == csum) begin
				for (int i = 0; i < words; i++)
					shown[i] = staged[i];
				r.frame_accepted = 1'b1;
			end else begin
				r.checksum_error = 1'b1;
			end
			phase = rcfd_pkg::PH_HUNT;
			pos = '0;
			csum = rcfd_pkg::CHECK_INIT;
		end
		endcase
		return r;
	endfunction

	function automatic void compare_field(string field, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s expected %h, got %h", $time, field, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			phase = rcfd_pkg::PH_HUNT;
			pos = '0;
			csum = rcfd_pkg::CHECK_INIT;
			low_hold = '0;
			chan_count = 4'd14;
			foreach (staged[i]) begin
				staged[i] = '0;
				shown[i] = '0;
			end
			owed_replies.delete();
			owed = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == COUNT_ADDR)
				chan_count = pwdata[rcfd_pkg::COUNT_W-1:0];
			if (req.valid && req.ready)
				owed_replies.push_back(decode_request(req.action, req.rx_byte,
					req.channel_number));
			if (rsp.valid && rsp.ready) begin
				if (owed_replies.size() == 0) begin
					fail_count++;
					$display("%0t: response with no request owed, got read_value %h ok %b err %b",
						$time, rsp.read_value, rsp.frame_accepted, rsp.checksum_error);
				end else begin
					want = owed_replies.pop_front();
					compare_field("read_value", want.read_value, rsp.read_value);
					compare_field("frame_accepted", 16'(want.frame_accepted),
						16'(rsp.frame_accepted));
					compare_field("checksum_error", 16'(want.checksum_error),
						16'(rsp.checksum_error));
				end
			end
			owed = owed_replies.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for rc_channel_frame_decoder: clock, reset, register writes, frame
// and read stimulus, response back-pressure, watchdog and verdict.
// Depends on rcfd_pkg, the channel interfaces, the decoder RTL and rcfd_checker.
module tb_top;

	localparam int WORDS_MAX   = 14;
	localparam int SEG_ITEMS   = 85;
	localparam int HOLD_CYCLES = 120;
	localparam int STALL_LIMIT = 2000;
	localparam logic [2:0] COUNT_ADDR = 3'(4 * rcfd_pkg::REG_CHANNEL_COUNT);

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	rcfd_req_if req_ch();
	rcfd_rsp_if rsp_ch();

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned fail_count;
	int unsigned owed;
	int unsigned items_sent;
	int unsigned quiet_cycles = 0;
	bit          hold_rsp_request = 1'b0;
	logic [rcfd_pkg::COUNT_W-1:0] count_now;

	always #5 clk = ~clk;

	rc_channel_frame_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	rcfd_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.owed       (owed)
	);

	// Response back-pressure; a requested hold-off is counted down here.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp_request) begin
				hold_rsp_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("rc_channel_frame_decoder: mismatch");
			$finish;
		end
	end

	// Offer one request and hold it until accepted.
	task automatic push_req(input logic act, input logic [rcfd_pkg::BYTE_W-1:0] b,
			input logic [rcfd_pkg::COUNT_W-1:0] num);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.rx_byte <= b;
		req_ch.channel_number <= num;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	task automatic push_byte(input logic [rcfd_pkg::BYTE_W-1:0] b);
		push_req(rcfd_pkg::ACT_BYTE, b, 4'($urandom_range(15)));
	endtask

	task automatic push_read(input logic [rcfd_pkg::COUNT_W-1:0] num);
		push_req(rcfd_pkg::ACT_READ, 8'($urandom_range(255)), num);
	endtask

	function automatic int unsigned frame_words();
		return (count_now > WORDS_MAX) ? WORDS_MAX : count_now;
	endfunction

	// Build a frame, optionally spoil its checksum or cut it short, and send it.
	task automatic send_frame(input int unsigned words, input bit corrupt, input bit truncate,
			input bit fixed_en, input logic [15:0] fixed_word);
		logic [7:0]  frame_bytes[$];
		logic [15:0] sum;
		logic [15:0] word;
		logic [15:0] check;
		int unsigned keep;
		frame_bytes.push_back(rcfd_pkg::SYNC_BYTE);
		frame_bytes.push_back(($urandom_range(7) == 0) ? rcfd_pkg::SYNC_BYTE
			: 8'($urandom_range(255)));
		for (int i = 0; i < words; i++) begin
			if (fixed_en) begin
				word = fixed_word;
			end else begin
				case ($urandom_range(7))
				0: word = '0;
				1: word = '1;
				default: word = 16'($urandom);
				endcase
			end
			frame_bytes.push_back(word[7:0]);
			frame_bytes.push_back(word[15:8]);
		end
		sum = '0;
		foreach (frame_bytes[i])
			sum = sum + 16'(frame_bytes[i]);
		check = rcfd_pkg::CHECK_INIT - sum;
		if (corrupt)
			check = check ^ (16'h1 << $urandom_range(15));
		frame_bytes.push_back(check[7:0]);
		frame_bytes.push_back(check[15:8]);
		keep = truncate ? $urandom_range(frame_bytes.size() - 2, 1) : frame_bytes.size();
		for (int i = 0; i < keep; i++) begin
			// reads may land anywhere inside a frame
			if (!fixed_en && $urandom_range(9) == 0)
				push_read(4'($urandom_range(15)));
			push_byte(frame_bytes[i]);
		end
	endtask

	task automatic run_mix(input int unsigned goal);
		int unsigned stop_at;
		int unsigned pick;
		stop_at = items_sent + goal;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 60)
				send_frame(frame_words(), 1'b0, 1'b0, 1'b0, '0);
			else if (pick < 72)
				send_frame(frame_words(), 1'b1, 1'b0, 1'b0, '0);
			else if (pick < 80)
				send_frame(frame_words(), 1'($urandom_range(1)), 1'b1, 1'b0, '0);
			else if (pick < 90)
				repeat ($urandom_range(6, 1)) push_read(4'($urandom_range(15)));
			else
				repeat ($urandom_range(4, 1)) push_byte(8'($urandom_range(255)));
		end
	endtask

	// Drain all responses, then write the channel count; optionally leave a frame open.
	task automatic reconfigure(input logic [rcfd_pkg::COUNT_W-1:0] n, input bit open_frame);
		if (open_frame)
			send_frame(frame_words(), 1'b0, 1'b1, 1'b0, '0);
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (owed != 0);
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= COUNT_ADDR;
		pwdata <= {28'($urandom), n};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		count_now = n;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.action = rcfd_pkg::ACT_BYTE;
		req_ch.rx_byte = '0;
		req_ch.channel_number = '0;
		send_idle_pct = 17;
		recv_idle_pct = 54;
		items_sent = 0;
		count_now = 4'd14;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store, hunting noise, one good and one bad single-word frame
		push_read(4'd0);
		push_read(4'd14);
		push_read(4'd15);
		reconfigure(4'd1, 1'b0);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h21);
		send_frame(1, 1'b0, 1'b0, 1'b1, 16'hFFFF);
		push_read(4'd1);
		push_read(4'd2);
		send_frame(1, 1'b1, 1'b0, 1'b1, 16'h0000);
		push_read(4'd1);
		push_read(4'd0);
		push_read(4'd15);

		// fill every staging entry with a clean full frame before the random mix
		reconfigure(4'd14, 1'b0);
		send_frame(WORDS_MAX, 1'b0, 1'b0, 1'b0, '0);
		run_mix(SEG_ITEMS);
		reconfigure(4'd0, 1'b1);
		run_mix(SEG_ITEMS);

		send_idle_pct = 54;
		recv_idle_pct = 17;
		reconfigure(4'd15, 1'b1);
		hold_rsp_request = 1'b1;
		run_mix(SEG_ITEMS);
		reconfigure(4'd7, 1'($urandom_range(1)));
		run_mix(SEG_ITEMS);
		reconfigure(4'd1, 1'($urandom_range(1)));
		run_mix(SEG_ITEMS);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		reconfigure(4'($urandom_range(14, 1)), 1'($urandom_range(1)));
		run_mix(SEG_ITEMS);
		reconfigure(4'd14, 1'($urandom_range(1)));
		run_mix(SEG_ITEMS);
		reconfigure(4'($urandom_range(15)), 1'($urandom_range(1)));
		run_mix(SEG_ITEMS);

		req_ch.valid <= 1'b0;
		do @(posedge clk); while (owed != 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("rc_channel_frame_decoder: match");
		else
			$display("rc_channel_frame_decoder: mismatch");
		$finish;
	end

endmodule
